[rtl/edf_frame_job_scheduler_unit_defines.svh]
// Assertion macros used by the scheduler sequencer, efjs_seq.
// Defining NO_ASSERTIONS removes every check from the build.
`ifndef EDF_FRAME_JOB_SCHEDULER_UNIT_DEFINES_SVH
`define EDF_FRAME_JOB_SCHEDULER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define EFJS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EFJS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define EFJS_ASSERT_IMPL(label, ante, cons, msg)
`define EFJS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/efjs_pkg.sv]
package efjs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;
   localparam int FRAME_BITS  = 16;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic [TIME_BITS-1:0] time_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_RUN    = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_INSERTED   = 2'd0,
      KIND_DROPPED    = 2'd1,
      KIND_EXECUTED   = 2'd2,
      KIND_IDLE_FRAME = 2'd3
   } kind_type;

   typedef struct packed {
      func_type    func;
      logic [4:0]  task_id;
      logic [9:0]  instance_req;
      logic [15:0] deadline;
      logic [15:0] exec_ticks;
   } req_word_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  done_task;
      logic [9:0]  done_instance;
      logic [15:0] finish_time;
      logic        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [4:0]  task_id;
      logic [9:0]  instance_id;
      logic [15:0] deadline;
      logic [15:0] exec_time;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_EVAL,
      ST_INS_LAST,
      ST_RUN_EVAL,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } push_type;

endpackage

[rtl/efjs_ram.sv]
module efjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/efjs_out.sv]
module efjs_out (
   input  logic                 clock,
   input  logic                 reset,
   input  efjs_pkg::push_type   push,
   output logic                 push_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output efjs_pkg::rsp_word_type rsp_word
);

   import efjs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // The register can take a new word when it is empty or its word leaves now.
   assign push_ready = !valid_ff || !rsp_stall;
   assign valid_in   = push_ready ? push.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ready && push.valid) begin
         word_ff <= push.word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

[rtl/efjs_seq.sv]
`include "edf_frame_job_scheduler_unit_defines.svh"

module efjs_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  efjs_pkg::req_word_type          req_word,
   input  logic [efjs_pkg::FRAME_BITS-1:0] frame_budget,
   output efjs_pkg::push_type              push,
   input  logic                            push_ready
);

   import efjs_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [IDX_BITS-1:0]   addr_ff, addr_in;
   logic [CNT_BITS-1:0]   wr_ff, wr_in;
   logic [FRAME_BITS-1:0] rem_ff, rem_in;
   time_type              frame_start_ff, frame_start_in;
   logic                  pend_job_ff, pend_job_in;
   rsp_word_type          pend_ff, pend_in;
   req_word_type          req_ff, req_in;

   logic                  ram_wr_en;
   logic [IDX_BITS-1:0]   ram_wr_addr;
   entry_type             ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   entry_type             rd_entry;
   entry_type             word_entry;
   entry_type             held_entry;
   logic                  accept;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  later;
   logic                  fits;
   logic                  walk_last;
   logic                  eval_blocked;
   logic [FRAME_BITS-1:0] rem_new;
   time_type              fin;
   time_type              frame_next;

   efjs_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry   = entry_type'(ram_rd_data);
   assign word_entry = '{task_id: req_word.task_id, instance_id: req_word.instance_req,
                         deadline: req_word.deadline, exec_time: req_word.exec_ticks};
   assign held_entry = '{task_id: req_ff.task_id, instance_id: req_ff.instance_req,
                         deadline: req_ff.deadline, exec_time: req_ff.exec_ticks};

   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign req_stall   = (state_ff != ST_IDLE);
   assign queue_full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);

   // Insert walks from the tail toward the head while the stored deadline is later.
   assign later = (rd_entry.deadline > req_ff.deadline);

   assign fits       = (rd_entry.exec_time <= rem_ff);
   assign walk_last  = ((CNT_BITS'(addr_ff) + CNT_BITS'(1)) == count_ff);
   assign rem_new    = rem_ff - rd_entry.exec_time;
   assign fin        = frame_start_ff + TIME_BITS'(frame_budget - rem_new);
   assign frame_next = frame_start_ff + TIME_BITS'(frame_budget);

   // A fitting job pushes out the job held before it, so the walk waits for the
   // output register only when such a job is held.
   assign eval_blocked = fits && pend_job_ff && !push_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.func == FUNC_RUN) begin
                  state_in = queue_empty ? ST_FLUSH : ST_RUN_EVAL;
               end else begin
                  state_in = (queue_full || queue_empty) ? ST_FLUSH : ST_INS_EVAL;
               end
            end
         end
         ST_INS_EVAL: begin
            if (!later) begin
               state_in = ST_FLUSH;
            end else if (addr_ff == '0) begin
               state_in = ST_INS_LAST;
            end
         end
         ST_INS_LAST: begin
            state_in = ST_FLUSH;
         end
         ST_RUN_EVAL: begin
            if (!eval_blocked && walk_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The write address always trails or leads the read address, so a read and a
   // write of the same entry never fall into one cycle.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      push        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.func == FUNC_RUN) begin
                  ram_rd_en = !queue_empty;
               end else if (queue_empty) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = word_entry;
               end else if (!queue_full) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_BITS'(count_ff - CNT_BITS'(1));
               end
            end
         end
         ST_INS_EVAL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff + IDX_BITS'(1);
            if (later) begin
               ram_wr_data = rd_entry;
               if (addr_ff != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = addr_ff - IDX_BITS'(1);
               end
            end else begin
               ram_wr_data = held_entry;
            end
         end
         ST_INS_LAST: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = held_entry;
         end
         ST_RUN_EVAL: begin
            if (!eval_blocked) begin
               if (fits) begin
                  push.valid = pend_job_ff;
                  push.word  = pend_ff;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = wr_ff[IDX_BITS-1:0];
                  ram_wr_data = rd_entry;
               end
               if (!walk_last) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = addr_ff + IDX_BITS'(1);
               end
            end
         end
         ST_FLUSH: begin
            push.valid            = 1'b1;
            push.word             = pend_ff;
            push.word.last_of_run = 1'b1;
         end
         default: begin
            push = '0;
         end
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      addr_in        = addr_ff;
      wr_in          = wr_ff;
      rem_in         = rem_ff;
      frame_start_in = frame_start_ff;
      pend_job_in    = pend_job_ff;
      pend_in        = pend_ff;
      req_in         = req_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_word;
               pend_job_in = 1'b0;
               if (req_word.func == FUNC_RUN) begin
                  rem_in  = frame_budget;
                  addr_in = '0;
                  wr_in   = '0;
                  pend_in = '{kind: KIND_IDLE_FRAME, done_task: '0, done_instance: '0,
                              finish_time: 16'(frame_start_ff), last_of_run: 1'b0};
                  if (queue_empty) begin
                     frame_start_in = frame_next;
                  end
               end else begin
                  pend_in = '{kind: queue_full ? KIND_DROPPED : KIND_INSERTED,
                              done_task: req_word.task_id,
                              done_instance: req_word.instance_req,
                              finish_time: '0, last_of_run: 1'b0};
                  addr_in = IDX_BITS'(count_ff - CNT_BITS'(1));
                  if (queue_empty) begin
                     count_in = CNT_BITS'(1);
                  end
               end
            end
         end
         ST_INS_EVAL: begin
            if (later && (addr_ff != '0)) begin
               addr_in = addr_ff - IDX_BITS'(1);
            end else if (!later) begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         ST_INS_LAST: begin
            count_in = count_ff + CNT_BITS'(1);
         end
         ST_RUN_EVAL: begin
            if (!eval_blocked) begin
               if (fits) begin
                  rem_in      = rem_new;
                  pend_job_in = 1'b1;
                  pend_in     = '{kind: KIND_EXECUTED, done_task: rd_entry.task_id,
                                  done_instance: rd_entry.instance_id,
                                  finish_time: 16'(fin), last_of_run: 1'b0};
               end else begin
                  wr_in = wr_ff + CNT_BITS'(1);
               end
               if (walk_last) begin
                  count_in       = fits ? wr_ff : (wr_ff + CNT_BITS'(1));
                  frame_start_in = frame_next;
               end else begin
                  addr_in = addr_ff + IDX_BITS'(1);
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         frame_start_ff <= '0;
         pend_job_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         frame_start_ff <= frame_start_in;
         pend_job_ff    <= pend_job_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      wr_ff   <= wr_in;
      rem_ff  <= rem_in;
      pend_ff <= pend_in;
      req_ff  <= req_in;
   end

   `EFJS_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_BITS'(QUEUE_DEPTH), "count beyond depth")
   `EFJS_ASSERT_IMPL(a_push_st, push.valid, state_ff == ST_RUN_EVAL || state_ff == ST_FLUSH, "bad push")
   `EFJS_ASSERT_IMPL(a_compact, state_ff == ST_RUN_EVAL, CNT_BITS'(addr_ff) >= wr_ff, "compact order")
   `EFJS_ASSERT_NEXT(a_flush_done, state_ff == ST_FLUSH && push_ready, state_ff == ST_IDLE, "flush stuck")

endmodule

[rtl/edf_frame_job_scheduler_unit.sv]
// Earliest-deadline-first ready queue of up to QUEUE_DEPTH jobs kept in one
// RAM with one write port and a registered read port. An insert into an empty
// queue writes the job at once; otherwise each queued job with a later deadline
// moves back one place, tail first, before the new job is written, and a full
// queue drops the job. A frame run reads every queued job once. Stalls on the
// result side hold up all of these. Each word is accepted only while the block
// is idle, and the last result of a word carries last_of_run. The user must
// write the frame size register only while idle; the block itself does not
// enforce it.
module edf_frame_job_scheduler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  efjs_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output efjs_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_write_en,
   input  logic [efjs_pkg::FRAME_BITS-1:0] csr_write_data
);

   import efjs_pkg::*;

   logic [FRAME_BITS-1:0] frame_budget_ff, frame_budget_in;
   push_type              push;
   logic                  push_ready;

   assign frame_budget_in = csr_write_en ? csr_write_data : frame_budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_budget_ff <= FRAME_BITS'(1);
      end else begin
         frame_budget_ff <= frame_budget_in;
      end
   end

   efjs_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .frame_budget (frame_budget_ff),
      .push         (push),
      .push_ready   (push_ready)
   );

   efjs_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

[dv/edf_frame_job_scheduler_unit_tb.sv]
module edf_frame_job_scheduler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import efjs_pkg::*;

   localparam int RANDOM_WORDS  = 380;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_WORDS   = RANDOM_WORDS / PHASE_COUNT + 1;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      bit                    is_cfg;
      logic [FRAME_BITS-1:0] cfg_value;
      req_word_type          word;
      bit                    has_fixed;
      rsp_word_type          fixed_rsp;
   } probe_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_write_en = 1'b0;
   logic [FRAME_BITS-1:0] csr_write_data = '0;

   // Shadow of the ready queue and the frame timing.
   entry_type             ready_jobs [QUEUE_DEPTH];
   int unsigned           job_count = 0;
   logic [FRAME_BITS-1:0] frame_len = 1;
   time_type              frame_origin = '0;

   rsp_word_type  caused_rsps[$];
   rsp_word_type  awaited_rsps[$];
   probe_row_type dir_rows[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   bit  hold_done = 1'b0;
   logic hold_request = 1'b0;
   logic quiet_stretch = 1'b0;

   edf_frame_job_scheduler_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Computes the results one accepted word causes and updates the shadow queue.
   function automatic void edf_schedule_word(input req_word_type w);
      rsp_word_type r;
      entry_type    job;
      int unsigned  slot;
      int unsigned  kept;
      int unsigned  budget_left;
      caused_rsps.delete();
      r = '0;
      r.last_of_run = 1'b1;
      if (w.func == FUNC_INSERT) begin
         r.done_task = w.task_id;
         r.done_instance = w.instance_req;
         if (job_count >= QUEUE_DEPTH) begin
            r.kind = KIND_DROPPED;
         end else begin
            job.task_id = w.task_id;
            job.instance_id = w.instance_req;
            job.deadline = w.deadline;
            job.exec_time = w.exec_ticks;
            slot = job_count;
            // Equal deadlines stay behind the jobs that arrived first.
            while (slot > 0 && ready_jobs[slot-1].deadline > w.deadline) begin
               ready_jobs[slot] = ready_jobs[slot-1];
               slot--;
            end
            ready_jobs[slot] = job;
            job_count++;
            r.kind = KIND_INSERTED;
         end
         caused_rsps.push_back(r);
      end else begin
         budget_left = frame_len;
         kept = 0;
         for (int unsigned i = 0; i < job_count; i++) begin
            if (ready_jobs[i].exec_time <= budget_left) begin
               budget_left -= ready_jobs[i].exec_time;
               r.kind = KIND_EXECUTED;
               r.done_task = ready_jobs[i].task_id;
               r.done_instance = ready_jobs[i].instance_id;
               r.finish_time = frame_origin + frame_len - budget_left;
               r.last_of_run = 1'b0;
               caused_rsps.push_back(r);
            end else begin
               ready_jobs[kept] = ready_jobs[i];
               kept++;
            end
         end
         job_count = kept;
         if (caused_rsps.size() == 0) begin
            r = '0;
            r.kind = KIND_IDLE_FRAME;
            r.finish_time = frame_origin;
            r.last_of_run = 1'b1;
            caused_rsps.push_back(r);
         end else begin
            r = caused_rsps.pop_back();
            r.last_of_run = 1'b1;
            caused_rsps.push_back(r);
         end
         frame_origin = frame_origin + frame_len;
      end
   endfunction

   function automatic req_word_type insert_word(input logic [4:0] task_id,
                                                input logic [9:0] instance_req,
                                                input logic [15:0] deadline,
                                                input logic [15:0] exec_ticks);
      req_word_type w;
      w.func = FUNC_INSERT;
      w.task_id = task_id;
      w.instance_req = instance_req;
      w.deadline = deadline;
      w.exec_ticks = exec_ticks;
      return w;
   endfunction

   function automatic rsp_word_type fixed_word(input kind_type kind,
                                               input logic [4:0] done_task,
                                               input logic [9:0] done_instance);
      rsp_word_type r;
      r = '0;
      r.kind = kind;
      r.done_task = done_task;
      r.done_instance = done_instance;
      r.last_of_run = 1'b1;
      return r;
   endfunction

   function automatic void add_row(input bit is_cfg, input logic [FRAME_BITS-1:0] cfg_value,
                                   input req_word_type w, input bit has_fixed,
                                   input rsp_word_type fixed_rsp);
      probe_row_type row;
      row.is_cfg = is_cfg;
      row.cfg_value = cfg_value;
      row.word = w;
      row.has_fixed = has_fixed;
      row.fixed_rsp = fixed_rsp;
      dir_rows.push_back(row);
   endfunction

   function automatic req_word_type random_job_word();
      req_word_type w;
      w.func = ($urandom_range(99) < 28) ? FUNC_RUN : FUNC_INSERT;
      w.task_id = 5'($urandom);
      w.instance_req = 10'($urandom);
      // A narrow set of deadlines makes ties common.
      if ($urandom_range(9) < 3) w.deadline = 16'($urandom_range(0, 7) * 8);
      else w.deadline = 16'($urandom);
      case ($urandom_range(9))
         0, 1:       w.exec_ticks = '0;
         2, 3, 4, 5: w.exec_ticks = 16'($urandom_range(0, frame_len / 4));
         6:          w.exec_ticks = 16'hFFFF;
         7:          w.exec_ticks = 16'($urandom);
         default:    w.exec_ticks = 16'($urandom_range(0, frame_len));
      endcase
      return w;
   endfunction

   // Offers one word, waits for its acceptance and queues what it should cause.
   task automatic offer_word(input req_word_type w, input bit allow_gap,
                             input bit use_fixed, input rsp_word_type fixed_rsp);
      if (allow_gap && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      edf_schedule_word(w);
      if (use_fixed) begin
         awaited_rsps.push_back(fixed_rsp);
      end else begin
         foreach (caused_rsps[k]) awaited_rsps.push_back(caused_rsps[k]);
      end
   endtask

   task automatic write_frame_size(input logic [FRAME_BITS-1:0] value);
      req_valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      frame_len = value;
   endtask

   task automatic check_rsp(input rsp_word_type got);
      rsp_word_type want;
      if (awaited_rsps.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: result word with nothing awaited: kind %0d task %0d inst %0d fin %0d last %0d",
                     $realtime, got.kind, got.done_task, got.done_instance, got.finish_time,
                     got.last_of_run);
         return;
      end
      want = awaited_rsps.pop_front();
      if (got.kind !== want.kind || got.done_task !== want.done_task ||
          got.done_instance !== want.done_instance ||
          got.finish_time !== want.finish_time || got.last_of_run !== want.last_of_run) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: result word mismatch", $realtime);
            $display("   expected kind %0d task %0d inst %0d fin %0d last %0d",
                     want.kind, want.done_task, want.done_instance, want.finish_time,
                     want.last_of_run);
            $display("   actual   kind %0d task %0d inst %0d fin %0d last %0d",
                     got.kind, got.done_task, got.done_instance, got.finish_time,
                     got.last_of_run);
         end
      end
   endtask

   // Result side: random short stalls, one long hold-off on request, none in the quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_rsp(rsp_word);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!quiet_stretch && $urandom_range(99) < 4) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [FRAME_BITS-1:0] phase_sizes [PHASE_COUNT];
      req_word_type          run_req;
      rsp_word_type          no_rsp;
      req_word_type          w;
      int                    n;

      run_req = '0;
      run_req.func = FUNC_RUN;
      no_rsp = '0;

      // Empty queue, a full queue with ties and extremes, a drop, then the frame size extremes.
      add_row(1'b0, '0, run_req, 1'b1, fixed_word(KIND_IDLE_FRAME, '0, '0));
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         case (i)
            0:       w = insert_word(5'd31, 10'd1023, 16'hFFFF, 16'd0);
            1:       w = insert_word(5'd0, 10'd0, 16'd0, 16'hFFFF);
            2:       w = insert_word(5'd9, 10'd100, 16'd100, 16'd0);
            3:       w = insert_word(5'd10, 10'd101, 16'd100, 16'd7);
            default: w = insert_word(5'(i), 10'(64 * i + 3), 16'(5000 - 300 * i),
                                     16'(1000 * (i - 4)));
         endcase
         add_row(1'b0, '0, w, 1'b1, fixed_word(KIND_INSERTED, w.task_id, w.instance_req));
      end
      w = insert_word(5'd21, 10'd777, 16'd1, 16'd1);
      add_row(1'b0, '0, w, 1'b1, fixed_word(KIND_DROPPED, w.task_id, w.instance_req));
      add_row(1'b1, 16'd0, run_req, 1'b0, no_rsp);
      add_row(1'b0, '0, run_req, 1'b0, no_rsp);
      add_row(1'b0, '0, run_req, 1'b0, no_rsp);
      add_row(1'b1, 16'hFFFF, run_req, 1'b0, no_rsp);
      add_row(1'b0, '0, run_req, 1'b0, no_rsp);

      phase_sizes[0] = 16'd250;
      phase_sizes[1] = 16'd0;
      phase_sizes[2] = 16'hFFFF;
      phase_sizes[3] = 16'd1;
      phase_sizes[4] = 16'd4000;
      phase_sizes[5] = 16'($urandom_range(2, 65534));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg)
            write_frame_size(dir_rows[i].cfg_value);
         else
            offer_word(dir_rows[i].word, 1'b1, dir_rows[i].has_fixed, dir_rows[i].fixed_rsp);
      end

      n = 0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_frame_size(phase_sizes[p]);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            // The long hold-off lands while words keep coming, so the queue backs up.
            if (n == 40) hold_request <= 1'b1;
            quiet_stretch <= (n >= 200 && n < 260);
            offer_word(random_job_word(), !(n >= 200 && n < 260), 1'b0, no_rsp);
            n++;
         end
      end

      req_valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
